@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge, held off while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clk edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/vps_pkg.sv @@
package vps_pkg;

    // field widths
    localparam int VEC_W   = 24;
    localparam int COEF_W  = 16;
    localparam int CFG_W   = 48;
    localparam int RAD_W   = 2;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int DEPTH_W = 8;
    localparam int IDX_W   = 3;

    // products and row sums of one matrix row
    localparam int PROD_W = VEC_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    // signed coordinate width, wide enough for every image size in range
    localparam int CRD_W = 24;

    // fixed point: Q3.20 times Q2.13 leaves 33 fraction bits
    localparam int FRAC_SHIFT   = 33;
    localparam int DEPTH_SCALE  = 64;
    localparam int DEPTH_OFFSET = 128;
    localparam int DEPTH_LIMIT  = 256;

    // default parameter values
    localparam int IMG_WIDTH_DEF  = 512;
    localparam int IMG_HEIGHT_DEF = 512;
    localparam int MAX_RADIUS_DEF = 3;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X     = 3'd0,
        REG_ROW_Y     = 3'd1,
        REG_ROW_DEPTH = 3'd2,
        REG_RADIUS    = 3'd3
    } cfg_reg_t;

    // projected point handed from the projection pipe to the splat stage
    typedef struct packed {
        logic [CRD_W-1:0] cx;
        logic [CRD_W-1:0] cy;
        logic [CRD_W-1:0] dz;
    } point_t;

endpackage

@@ hw/rtl/vps_proj.sv @@
module vps_proj #(
    parameter int IMG_WIDTH  = vps_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = vps_pkg::IMG_HEIGHT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [2:0][vps_pkg::CFG_W-1:0]        coefs,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vps_pkg::VEC_W-1:0]      vec_x,
    input  logic signed [vps_pkg::VEC_W-1:0]      vec_y,
    input  logic signed [vps_pkg::VEC_W-1:0]      vec_z,
    output logic                                  pt_valid,
    input  logic                                  pt_take,
    output vps_pkg::point_t                       pt
);
    import vps_pkg::*;

    localparam int XY_SCALE  = (IMG_WIDTH + IMG_HEIGHT) / 4;
    localparam int MAX_SCALE = (XY_SCALE > DEPTH_SCALE) ? XY_SCALE : DEPTH_SCALE;
    localparam int SCL_W     = $clog2(MAX_SCALE + 1) + 1;
    localparam int PW        = SUM_W + SCL_W;
    localparam int QW        = PW - FRAC_SHIFT;
    localparam int NSTG      = 5;

    localparam logic signed [PW-1:0] SCALE_XY = PW'(XY_SCALE);
    localparam logic signed [PW-1:0] SCALE_D  = PW'(DEPTH_SCALE);
    localparam logic signed [PW-1:0] TRUNC_BIAS =
        {{(PW-FRAC_SHIFT){1'b0}}, {FRAC_SHIFT{1'b1}}};
    localparam logic signed [CRD_W-1:0] OFS_X = CRD_W'(IMG_WIDTH / 2);
    localparam logic signed [CRD_W-1:0] OFS_Y = CRD_W'(IMG_HEIGHT / 2);
    localparam logic signed [CRD_W-1:0] OFS_D = CRD_W'(DEPTH_OFFSET);

    // stage valids and elastic ready chain
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] rdy;

    logic signed [VEC_W-1:0]  vec_reg  [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next[3][3];
    logic signed [SUM_W-1:0]  sum_reg  [3];
    logic signed [SUM_W-1:0]  sum_next [3];
    logic signed [PW-1:0]     scl_reg  [3];
    logic signed [PW-1:0]     scl_next [3];
    logic signed [CRD_W-1:0]  crd_reg  [3];
    logic signed [CRD_W-1:0]  crd_next [3];

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        rdy[NSTG] = !vld_reg[NSTG] || pt_take;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_stall = !rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // one product per coefficient and component
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_next[r][i] = $signed(coefs[r][COEF_W*i +: COEF_W]) * vec_reg[i];
            end
        end
    end

    // row sums
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = {{2{prod_reg[r][0][PROD_W-1]}}, prod_reg[r][0]}
                        + {{2{prod_reg[r][1][PROD_W-1]}}, prod_reg[r][1]}
                        + {{2{prod_reg[r][2][PROD_W-1]}}, prod_reg[r][2]};
        end
    end

    // row scale by a constant
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            scl_next[r] = {{(PW-SUM_W){sum_reg[r][SUM_W-1]}}, sum_reg[r]}
                        * ((r == 2) ? SCALE_D : SCALE_XY);
        end
    end

    // truncate toward zero, then add the image center offset, or the depth offset for the depth row
    always_comb
    begin
        logic signed [PW-1:0] biased;
        logic signed [QW-1:0] quo;
        for (int r = 0; r < 3; r++)
        begin
            biased = scl_reg[r] + (scl_reg[r][PW-1] ? TRUNC_BIAS : '0);
            quo = biased[PW-1:FRAC_SHIFT];
            crd_next[r] = {{(CRD_W-QW){quo[QW-1]}}, quo}
                        + ((r == 0) ? OFS_X : ((r == 1) ? OFS_Y : OFS_D));
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            vec_reg[0] <= vec_x;
            vec_reg[1] <= vec_y;
            vec_reg[2] <= vec_z;
        end
        if (rdy[2])
        begin
            prod_reg <= prod_next;
        end
        if (rdy[3])
        begin
            sum_reg <= sum_next;
        end
        if (rdy[4])
        begin
            scl_reg <= scl_next;
        end
        if (rdy[5])
        begin
            crd_reg <= crd_next;
        end
    end

    assign pt_valid = vld_reg[NSTG];
    assign pt.cx    = crd_reg[0];
    assign pt.cy    = crd_reg[1];
    assign pt.dz    = crd_reg[2];

endmodule

@@ hw/rtl/vps_splat.sv @@
`include "assert_macros.svh"

module vps_splat #(
    parameter int IMG_WIDTH  = vps_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = vps_pkg::IMG_HEIGHT_DEF,
    parameter int MAX_RADIUS = vps_pkg::MAX_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [vps_pkg::RAD_W-1:0]         radius,
    input  logic                              pt_valid,
    output logic                              pt_take,
    input  vps_pkg::point_t                   pt,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [vps_pkg::COL_W-1:0]         pix_col,
    output logic [vps_pkg::ROW_W-1:0]         pix_row,
    output logic [vps_pkg::DEPTH_W-1:0]       depth_alpha,
    output logic                              last_pixel
);
    import vps_pkg::*;

    localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 2);
    localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);
    localparam logic signed [CRD_W-1:0] COL_LIM   = CRD_W'(IMG_WIDTH);
    localparam logic signed [CRD_W-1:0] ROW_LIM   = CRD_W'(IMG_HEIGHT);
    localparam logic signed [CRD_W-1:0] DEPTH_LIM = CRD_W'(DEPTH_LIMIT);

    logic                 out_valid_reg, out_valid_next;
    logic                 last_reg, last_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [COL_W-1:0]     col_start_reg, col_start_next;
    logic [SPAN_W-1:0]    k_reg, k_next;
    logic [SPAN_W-1:0]    j_reg, j_next;
    logic [SPAN_W-1:0]    span_reg, span_next;

    logic [RAD_W-1:0]        r_sat;
    logic signed [CRD_W-1:0] r_crd;
    logic                    in_range;
    logic                    out_adv;
    logic                    more;
    logic                    load;

    // radius clamp and margin test of the incoming point
    assign r_sat = (radius > RAD_MAX) ? RAD_MAX : radius;
    assign r_crd = {{(CRD_W-RAD_W){1'b0}}, r_sat};
    assign in_range = ($signed(pt.cx) > r_crd) && ($signed(pt.cx) < COL_LIM - r_crd)
                   && ($signed(pt.cy) > r_crd) && ($signed(pt.cy) < ROW_LIM - r_crd)
                   && ($signed(pt.dz) >= $signed(CRD_W'(0)))
                   && ($signed(pt.dz) < DEPTH_LIM);

    // output register frees up when empty or taken
    assign out_adv = !out_valid_reg || !out_stall;
    assign more    = out_valid_reg && !last_reg;
    assign load    = out_adv && !more && pt_valid && in_range;
    assign pt_take = pt_valid && (!in_range || (out_adv && !more));

    // walk the square row by row
    always_comb
    begin
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        depth_next     = depth_reg;
        col_start_next = col_start_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        span_next      = span_reg;
        if (out_adv)
        begin
            if (more)
            begin
                if (k_reg == span_reg)
                begin
                    k_next   = '0;
                    col_next = col_start_reg;
                    j_next   = j_reg + 1'b1;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    k_next   = k_reg + 1'b1;
                    col_next = col_reg + 1'b1;
                end
                last_next = (k_next == span_reg) && (j_next == span_reg);
            end
            else if (load)
            begin
                out_valid_next = 1'b1;
                span_next      = SPAN_W'({r_sat, 1'b0});
                col_start_next = pt.cx[COL_W-1:0] - COL_W'(r_sat);
                col_next       = pt.cx[COL_W-1:0] - COL_W'(r_sat);
                row_next       = pt.cy[ROW_W-1:0] - ROW_W'(r_sat);
                depth_next     = pt.dz[DEPTH_W-1:0];
                k_next         = '0;
                j_next         = '0;
                last_next      = (r_sat == '0);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // payload and square counters
    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        depth_reg     <= depth_next;
        col_start_reg <= col_start_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        span_reg      <= span_next;
    end

    assign out_valid   = out_valid_reg;
    assign pix_col     = col_reg;
    assign pix_row     = row_reg;
    assign depth_alpha = depth_reg;
    assign last_pixel  = last_reg;

    // checks
    `ASSERT_CLK(a_last_at_corner, out_valid_reg && last_reg |-> (k_reg == span_reg) && (j_reg == span_reg), "last write flagged before the square corner")
    `ASSERT_CLK(a_cnt_in_span, out_valid_reg |-> (k_reg <= span_reg) && (j_reg <= span_reg), "square counter past its span")
    `ASSERT_CLK(a_no_gap, out_valid_reg && !out_stall && !last_reg |=> out_valid_reg, "square cut short")
    `ASSERT_CLK(a_col_track, out_valid_reg |-> col_reg == COL_W'(col_start_reg + COL_W'(k_reg)), "column out of step with counter")
    `ASSERT_CLK_ALWAYS(a_take_needs_valid, pt_take |-> pt_valid, "point taken while none offered")

endmodule

@@ hw/rtl/vector_projection_splatter.sv @@
// path: a vector passes the vec, prod, sum, scl and crd stages, then the output register
// throughput: one vector per cycle enters while in_stall is low; an in-range vector
// then holds the output register for (2r+1)^2 pixel writes (9 at radius 1), while
// later vectors move up behind it in the 5-stage projection pipe until it is full
// reset: rst_n clears all valids, coefficients to zero and the splat radius to 1
module vector_projection_splatter #(
    parameter int IMG_WIDTH  = vps_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = vps_pkg::IMG_HEIGHT_DEF,
    parameter int MAX_RADIUS = vps_pkg::MAX_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vps_pkg::IDX_W-1:0]         cfg_index,
    input  logic [vps_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [vps_pkg::VEC_W-1:0]  vec_x,
    input  logic signed [vps_pkg::VEC_W-1:0]  vec_y,
    input  logic signed [vps_pkg::VEC_W-1:0]  vec_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [vps_pkg::COL_W-1:0]         pix_col,
    output logic [vps_pkg::ROW_W-1:0]         pix_row,
    output logic [vps_pkg::DEPTH_W-1:0]       depth_alpha,
    output logic                              last_pixel
);
    import vps_pkg::*;

    logic [2:0][CFG_W-1:0] coefs_reg;
    logic [RAD_W-1:0]      radius_reg;
    logic                  pt_valid;
    logic                  pt_take;
    point_t                pt;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg  <= '0;
            radius_reg <= RAD_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_X:     coefs_reg[0] <= cfg_data;
                REG_ROW_Y:     coefs_reg[1] <= cfg_data;
                REG_ROW_DEPTH: coefs_reg[2] <= cfg_data;
                REG_RADIUS:    radius_reg   <= cfg_data[RAD_W-1:0];
                default:       ;
            endcase
        end
    end

    // matrix projection pipe
    vps_proj #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .coefs    (coefs_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .pt_valid (pt_valid),
        .pt_take  (pt_take),
        .pt       (pt)
    );

    // margin test and square walk
    vps_splat #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_splat (
        .clk         (clk),
        .rst_n       (rst_n),
        .radius      (radius_reg),
        .pt_valid    (pt_valid),
        .pt_take     (pt_take),
        .pt          (pt),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pix_col     (pix_col),
        .pix_row     (pix_row),
        .depth_alpha (depth_alpha),
        .last_pixel  (last_pixel)
    );

endmodule
